// ===== sv/ddfe_pkg.sv =====
// Shared types and constants for the delimited decimal field extractor.
`timescale 1ns / 1ps

package ddfe_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_DELIMITER = 2'd0;
  localparam cfg_idx_t REG_FIELD_NUM = 2'd1;

  // Reset values of the configuration registers.
  localparam byte_t DELIM_RESET     = 8'd95;
  localparam byte_t FIELD_NUM_RESET = 8'd2;

  // Character codes.
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;

  // Result request from the scanner to the output register.
  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] value;
  } scan_res_t;

endpackage

// ===== sv/ddfe_in_stage.sv =====
// Input register for the text byte stream with its valid/ready handshake.
`timescale 1ns / 1ps

module ddfe_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ddfe_pkg::byte_t in_byte,
  input  logic           advance,
  output logic           hold_valid,
  output ddfe_pkg::byte_t hold_byte
);

  logic            valid_r;
  logic            valid_nxt;
  ddfe_pkg::byte_t byte_r;

  // The register frees up in the same cycle its content moves on.
  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== sv/ddfe_scan.sv =====
// Field scanner: configuration, delimiter count, sign and decimal accumulator.
`timescale 1ns / 1ps

module ddfe_scan #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  ddfe_pkg::byte_t     text_byte,
  input  logic                cfg_wr_en,
  input  ddfe_pkg::cfg_idx_t  cfg_index,
  input  ddfe_pkg::byte_t     cfg_wdata,
  output ddfe_pkg::scan_res_t res
);

  ddfe_pkg::byte_t delim_r, delim_nxt;
  ddfe_pkg::byte_t field_num_r, field_num_nxt;
  ddfe_pkg::byte_t delims_r, delims_nxt;
  logic            in_field_r, in_field_nxt;
  logic            sign_pend_r, sign_pend_nxt;
  logic            neg_r, neg_nxt;
  logic            given_r, given_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;

  logic [VALUE_BITS-1:0] acc_step;
  logic [VALUE_BITS-1:0] signed_v;
  logic [ddfe_pkg::OUT_W-1:0] out_v;
  logic is_digit;
  logic is_sign;

  assign is_digit = (text_byte >= ddfe_pkg::CH_ZERO) && (text_byte <= ddfe_pkg::CH_NINE);
  assign is_sign  = (text_byte == ddfe_pkg::CH_MINUS) || (text_byte == ddfe_pkg::CH_PLUS);

  // acc * 10 + digit; the digit is the low nibble of an ASCII digit.
  assign acc_step = (acc_r << 3) + (acc_r << 1)
                  + {{(VALUE_BITS-4){1'b0}}, text_byte[3:0]};

  assign signed_v = neg_r ? (~acc_r + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : acc_r;

  // The value wraps at VALUE_BITS and is then zero-extended or cut to the port width.
  generate
    if (VALUE_BITS >= ddfe_pkg::OUT_W) begin : g_cut
      assign out_v = signed_v[ddfe_pkg::OUT_W-1:0];
    end else begin : g_ext
      assign out_v = {{(ddfe_pkg::OUT_W-VALUE_BITS){1'b0}}, signed_v};
    end
  endgenerate

  always_comb begin
    delim_nxt     = delim_r;
    field_num_nxt = field_num_r;
    delims_nxt    = delims_r;
    in_field_nxt  = in_field_r;
    sign_pend_nxt = sign_pend_r;
    neg_nxt       = neg_r;
    given_nxt     = given_r;
    acc_nxt       = acc_r;
    res.emit      = 1'b0;
    res.value     = out_v;

    if (cfg_wr_en) begin
      case (cfg_index)
        ddfe_pkg::REG_DELIMITER: begin
          delim_nxt = cfg_wdata;
        end
        ddfe_pkg::REG_FIELD_NUM: begin
          // A new field number restarts the scan as at a record start.
          field_num_nxt = cfg_wdata;
          delims_nxt    = cfg_wdata;
          in_field_nxt  = (cfg_wdata == '0);
          sign_pend_nxt = 1'b0;
          neg_nxt       = 1'b0;
          given_nxt     = 1'b0;
          acc_nxt       = '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (text_byte == ddfe_pkg::CH_NUL) begin
        res.emit      = !given_r;
        delims_nxt    = field_num_r;
        in_field_nxt  = (field_num_r == '0);
        sign_pend_nxt = 1'b0;
        neg_nxt       = 1'b0;
        given_nxt     = 1'b0;
        acc_nxt       = '0;
      end else if (given_r) begin
        // Rest of the record is ignored.
      end else if (!in_field_r) begin
        if ((text_byte == delim_r) && (delims_r != '0)) begin
          delims_nxt = delims_r - 8'd1;
          if (delims_r == 8'd1) begin
            in_field_nxt = 1'b1;
          end
        end
      end else if (sign_pend_r) begin
        sign_pend_nxt = 1'b0;
        if (is_digit) begin
          acc_nxt = acc_step;
        end else begin
          res.emit  = 1'b1;
          given_nxt = 1'b1;
        end
      end else if (is_sign) begin
        neg_nxt       = (text_byte == ddfe_pkg::CH_MINUS);
        sign_pend_nxt = 1'b1;
      end else if (is_digit) begin
        acc_nxt = acc_step;
      end else begin
        res.emit  = 1'b1;
        given_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= ddfe_pkg::DELIM_RESET;
      field_num_r <= ddfe_pkg::FIELD_NUM_RESET;
      delims_r    <= ddfe_pkg::FIELD_NUM_RESET;
      in_field_r  <= 1'b0;
      sign_pend_r <= 1'b0;
      neg_r       <= 1'b0;
      given_r     <= 1'b0;
      acc_r       <= '0;
    end else begin
      delim_r     <= delim_nxt;
      field_num_r <= field_num_nxt;
      delims_r    <= delims_nxt;
      in_field_r  <= in_field_nxt;
      sign_pend_r <= sign_pend_nxt;
      neg_r       <= neg_nxt;
      given_r     <= given_nxt;
      acc_r       <= acc_nxt;
    end
  end

endmodule

// ===== sv/ddfe_out_stage.sv =====
// Result register holding one field value until the consumer takes it.
`timescale 1ns / 1ps

module ddfe_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ddfe_pkg::scan_res_t        res,
  output logic                       space,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ddfe_pkg::OUT_W-1:0] out_value
);

  logic                       valid_r, valid_nxt;
  logic [ddfe_pkg::OUT_W-1:0] value_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      value_r <= res.value;
    end
  end

endmodule

// ===== sv/delimited_decimal_field_extractor.sv =====
// Top level of the delimited decimal field extractor.
// Takes one text byte per cycle while in_ready is high and gives the signed decimal
// value of the selected field once per record: when the field ends on a non-digit,
// or at the zero byte that closes the record (zero if the field never came). An
// accepted byte sits in the input register; when it moves on, the scanner updates
// its state and loads the result register. With out_ready held high the block
// sustains one byte per cycle; a held result stalls the input only while the input
// register is full.
// Configuration writes take effect at once; write only while no byte is in flight.
`timescale 1ns / 1ps

module delimited_decimal_field_extractor #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_text_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_field_value,
  input  logic                              cfg_wr_en,
  input  logic [ddfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_wdata
);

  logic                 hold_valid;
  ddfe_pkg::byte_t      hold_byte;
  logic                 space;
  logic                 advance;
  ddfe_pkg::scan_res_t  res;
  logic [31:0]          out_value;

  assign advance = hold_valid && space;
  assign out_field_value = signed'(out_value);

  ddfe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_text_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  ddfe_scan #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (advance),
    .text_byte (hold_byte),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  ddfe_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

endmodule

// ===== sv/ddfe_checker.sv =====
// Port-level checks for the delimited decimal field extractor, bound to the top level.
`timescale 1ns / 1ps

module ddfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_field_value
);

  // A result held back by the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_value))
    else $error("result changed or dropped while stalled");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the input side always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A fresh result must trace back to an accepted input request.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input request");

endmodule

bind delimited_decimal_field_extractor ddfe_checker u_ddfe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_field_value (out_field_value)
);

// ===== tb/tb_delimited_decimal_field_extractor.sv =====
// Self-checking testbench for the delimited decimal field extractor.
`timescale 1ns / 1ps

// Tracks the scan state of the block and keeps the field values it should return.
class field_value_tracker;
  ddfe_pkg::byte_t delim_char;
  ddfe_pkg::byte_t field_count;
  ddfe_pkg::byte_t delims_left;
  bit in_field;
  bit sign_seen;
  bit negate;
  bit done;
  logic [31:0] acc;
  logic signed [31:0] expected_values[$];

  function void reset_state();
    delim_char  = ddfe_pkg::DELIM_RESET;
    field_count = ddfe_pkg::FIELD_NUM_RESET;
    expected_values.delete();
    restart();
  endfunction

  function void restart();
    delims_left = field_count;
    in_field    = (field_count == 8'd0);
    sign_seen   = 1'b0;
    negate      = 1'b0;
    acc         = 32'd0;
    done        = 1'b0;
  endfunction

  function void configure(ddfe_pkg::cfg_idx_t idx, ddfe_pkg::byte_t val);
    case (idx)
      ddfe_pkg::REG_DELIMITER: begin
        delim_char = val;
      end
      ddfe_pkg::REG_FIELD_NUM: begin
        field_count = val;
        restart();
      end
      default: begin
      end
    endcase
  endfunction

  function logic signed [31:0] current_value();
    return negate ? -acc : acc;
  endfunction

  function bit is_digit(ddfe_pkg::byte_t b);
    return (b >= ddfe_pkg::CH_ZERO) && (b <= ddfe_pkg::CH_NINE);
  endfunction

  function void add_digit(ddfe_pkg::byte_t b);
    acc = acc * 32'd10 + 32'(b - ddfe_pkg::CH_ZERO);
  endfunction

  function void note_byte(ddfe_pkg::byte_t b);
    if (b == ddfe_pkg::CH_NUL) begin
      if (!done) expected_values.push_back(current_value());
      restart();
      return;
    end
    if (done) return;
    if (!in_field) begin
      if (b == delim_char && delims_left != 8'd0) begin
        delims_left--;
        if (delims_left == 8'd0) in_field = 1'b1;
      end
      return;
    end
    if (sign_seen) begin
      // A sign only stays part of the field when a digit follows it.
      sign_seen = 1'b0;
      if (is_digit(b)) begin
        add_digit(b);
        return;
      end
    end else if (b == ddfe_pkg::CH_MINUS || b == ddfe_pkg::CH_PLUS) begin
      negate    = (b == ddfe_pkg::CH_MINUS);
      sign_seen = 1'b1;
      return;
    end else if (is_digit(b)) begin
      add_digit(b);
      return;
    end
    expected_values.push_back(current_value());
    done = 1'b1;
  endfunction

  function int pending();
    return expected_values.size();
  endfunction

  function bit check_value(logic signed [31:0] got, output string msg);
    logic signed [31:0] want;
    msg = "";
    if (expected_values.size() == 0) begin
      msg = $sformatf("unexpected field_value %0d", got);
      return 1'b0;
    end
    want = expected_values.pop_front();
    if (got !== want) begin
      msg = $sformatf("field_value %0d, expected %0d", got, want);
      return 1'b0;
    end
    return 1'b1;
  endfunction
endclass

module tb_delimited_decimal_field_extractor;

  localparam ddfe_pkg::cfg_idx_t REG_SPARE_A = 2'd2;
  localparam ddfe_pkg::cfg_idx_t REG_SPARE_B = 2'd3;
  localparam int NUM_PHASES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_text_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_field_value;
  logic cfg_wr_en = 1'b0;
  ddfe_pkg::cfg_idx_t cfg_index = ddfe_pkg::REG_DELIMITER;
  logic [7:0] cfg_wdata = 8'd0;

  field_value_tracker tracker = new();
  int errors = 0;
  int bytes_sent = 0;
  bit gaps_on = 1'b1;
  int hold_req = 0;
  int stall_left = 0;
  int hold_left = 0;

  delimited_decimal_field_extractor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_field_value (out_field_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb_delimited_decimal_field_extractor: done, errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Result side: checks every accepted result and stalls in random bursts or for a requested hold.
  initial begin
    string msg;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (!tracker.check_value(out_field_value, msg)) report_mismatch(msg);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(ddfe_pkg::byte_t b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_record(string s);
    for (int i = 0; i < s.len(); i++) send_byte(ddfe_pkg::byte_t'(s[i]));
    send_byte(ddfe_pkg::CH_NUL);
  endtask

  task automatic write_cfg(ddfe_pkg::cfg_idx_t idx, ddfe_pkg::byte_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.configure(idx, val);
    @(posedge clk);
  endtask

  // Wait until every expected value is back, then let bytes without a result
  // clear the two-stage pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic ddfe_pkg::byte_t noise_byte(ddfe_pkg::byte_t delim);
    ddfe_pkg::byte_t b;
    do b = ddfe_pkg::byte_t'($urandom_range(1, 255)); while (b == delim);
    return b;
  endfunction

  function automatic ddfe_pkg::byte_t sign_byte();
    return ($urandom_range(0, 1) == 0) ? ddfe_pkg::CH_MINUS : ddfe_pkg::CH_PLUS;
  endfunction

  function automatic ddfe_pkg::byte_t digit_byte();
    return ddfe_pkg::CH_ZERO + ddfe_pkg::byte_t'($urandom_range(0, 9));
  endfunction

  function automatic ddfe_pkg::byte_t any_byte(ddfe_pkg::byte_t delim);
    case ($urandom_range(0, 5))
      0, 1: return digit_byte();
      2: return sign_byte();
      3: return (delim != ddfe_pkg::CH_NUL) ? delim
                                            : ddfe_pkg::byte_t'($urandom_range(1, 255));
      default: return ddfe_pkg::byte_t'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly well-formed records that reach the wanted field, plus broken ones.
  function automatic void build_record(ddfe_pkg::byte_t delim, ddfe_pkg::byte_t fnum,
                                       ref ddfe_pkg::byte_t rec[$]);
    int kind;
    int ndig;
    int max_noise;
    kind = $urandom_range(0, 9);
    max_noise = (fnum > 8) ? 1 : 3;
    rec.delete();
    if (kind <= 6) begin
      for (int k = 0; k < fnum; k++) begin
        repeat ($urandom_range(0, max_noise)) rec.push_back(noise_byte(delim));
        if (delim != ddfe_pkg::CH_NUL) rec.push_back(delim);
      end
      if ($urandom_range(0, 2) == 0) rec.push_back(sign_byte());
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
      for (int k = 0; k < ndig; k++) begin
        if ($urandom_range(0, 11) == 0) rec.push_back(sign_byte());
        rec.push_back(digit_byte());
      end
      case ($urandom_range(0, 4))
        0: begin
        end
        1: rec.push_back((delim != ddfe_pkg::CH_NUL) ? delim : noise_byte(delim));
        2: rec.push_back(sign_byte());
        3: rec.push_back(noise_byte(delim));
        default: begin
          rec.push_back(sign_byte());
          rec.push_back(sign_byte());
        end
      endcase
      repeat ($urandom_range(0, 4)) rec.push_back(any_byte(delim));
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 20)) rec.push_back(any_byte(delim));
    end else begin
      repeat ($urandom_range(1, 10)) rec.push_back(noise_byte(delim));
    end
    rec.push_back(ddfe_pkg::CH_NUL);
  endfunction

  initial begin
    ddfe_pkg::byte_t delim_plan[NUM_PHASES];
    ddfe_pkg::byte_t field_plan[NUM_PHASES];
    int budget_plan[NUM_PHASES];
    ddfe_pkg::byte_t rec[$];
    int phase_end;

    delim_plan  = '{8'h4D, 8'h5F, 8'h00, 8'hFF, 8'h30, 8'h2D, 8'h5F, 8'h4D};
    field_plan  = '{8'd1, 8'd0, 8'd3, 8'd255, 8'd4, 8'd1, 8'd2, 8'd0};
    budget_plan = '{250, 250, 60, 500, 250, 200, 200, 200};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tracker.reset_state();

    // Directed records under the reset setting: delimiter underscore, third field.
    send_byte(8'h01);
    send_record("__-7");
    send_record("");
    send_byte("_");
    send_byte(8'hFF);
    send_record("_9-+");
    send_record("__12_");
    send_record("__+");
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      gaps_on = (p != NUM_PHASES - 1);
      write_cfg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                ddfe_pkg::byte_t'($urandom_range(0, 255)));
      write_cfg(ddfe_pkg::REG_DELIMITER, delim_plan[p]);
      write_cfg(ddfe_pkg::REG_FIELD_NUM, field_plan[p]);
      // First-field records give a result per few bytes, so a long hold on
      // the result side here backs the block up into its input.
      if (p == 1) hold_req = 150;
      phase_end = bytes_sent + budget_plan[p];
      while (bytes_sent < phase_end) begin
        build_record(delim_plan[p], field_plan[p], rec);
        foreach (rec[i]) send_byte(rec[i]);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_delimited_decimal_field_extractor: done, clean");
    end else begin
      $display("tb_delimited_decimal_field_extractor: done, errors");
    end
    $finish;
  end
endmodule
